/* rtl/unordered_key_value_table_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the unordered key/value table.
// Concurrent checks that fall away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef UNORDERED_KEY_VALUE_TABLE_ASSERT_SVH
`define UNORDERED_KEY_VALUE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define UKVT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define UKVT_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define UKVT_ASSERT(lbl, clk, rst, prop, msg)
`define UKVT_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

/* rtl/ukvt_pkg.sv */
// ---------------------------------------------------------------------------
// ukvt_pkg
// Types, codes and widths shared by the key/value table modules.
// ---------------------------------------------------------------------------
package ukvt_pkg;

  localparam int FUNC_W    = 2;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 5;
  localparam int DEPTH_DEF = 16;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_DELETE = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Read address source for the entry RAM.
  typedef enum logic [1:0] {
    RD_NEXT = 2'd0,
    RD_ZERO = 2'd1,
    RD_LAST = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    latch;
    logic    ins_write;
    logic    move_write;
    logic    idx_clear;
    logic    idx_step;
    rd_sel_t rd_sel;
    logic    res_load;
    status_t res_status;
    logic    res_take_data;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  room;
    logic  empty;
    logic  hit;
    logic  last;
    logic  out_free;
  } sts_t;

  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

/* rtl/ukvt_ram.sv */
// ---------------------------------------------------------------------------
// ukvt_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module ukvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [ukvt_pkg::addr_w(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [ukvt_pkg::addr_w(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/ukvt_dp.sv */
// ---------------------------------------------------------------------------
// ukvt_dp
// Datapath: operand and capacity registers, fill count, scan index,
// entry RAM and the result and output registers.
// ---------------------------------------------------------------------------
`include "unordered_key_value_table_assert.svh"

module ukvt_dp #(
  parameter int DEPTH = ukvt_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ukvt_pkg::cmd_t                 cmd,
  output ukvt_pkg::sts_t                 sts,
  input  logic                           cfg_wen,
  input  logic [ukvt_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic [ukvt_pkg::FUNC_W-1:0]    func,
  input  logic [ukvt_pkg::KEY_W-1:0]     key,
  input  logic [ukvt_pkg::VAL_W-1:0]     value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ukvt_pkg::STATUS_W-1:0]  status,
  output logic [ukvt_pkg::VAL_W-1:0]     found_value,
  output logic [ukvt_pkg::CNT_W-1:0]     entry_count
);
  import ukvt_pkg::*;

  localparam int AW = addr_w(DEPTH);
  localparam int EW = KEY_W + VAL_W;

  logic [FUNC_W-1:0]   op_func;
  logic [KEY_W-1:0]    op_key;
  logic [VAL_W-1:0]    op_value;
  logic [CNT_W-1:0]    capacity;
  logic [CNT_W-1:0]    count;
  logic [AW-1:0]       cmp_idx;
  logic [STATUS_W-1:0] res_status;
  logic [VAL_W-1:0]    res_found;
  logic [STATUS_W-1:0] out_status;
  logic [VAL_W-1:0]    out_found;
  logic [CNT_W-1:0]    out_count;

  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  logic [EW-1:0]       ram_wr_data;
  logic [AW-1:0]       ram_rd_addr;
  logic [EW-1:0]       ram_rd_data;
  logic [AW-1:0]       last_idx;
  logic                out_free;

  assign last_idx = AW'(count - 1'b1);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_func  <= func;
      op_key   <= key;
      op_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_write) begin
      count <= count + 1'b1;
    end else if (cmd.move_write) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clear) begin
      cmp_idx <= '0;
    end else if (cmd.idx_step) begin
      cmp_idx <= cmp_idx + 1'b1;
    end
  end

  // Insert appends at the fill count; delete moves the last entry into the hit slot.
  always_comb begin
    ram_wr_en   = cmd.ins_write || cmd.move_write;
    ram_wr_addr = cmd.move_write ? cmp_idx : AW'(count);
    ram_wr_data = cmd.move_write ? ram_rd_data : {op_key, op_value};
    case (cmd.rd_sel)
      RD_ZERO: ram_rd_addr = '0;
      RD_LAST: ram_rd_addr = last_idx;
      default: ram_rd_addr = cmp_idx + 1'b1;
    endcase
  end

  ukvt_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_found  <= cmd.res_take_data ? ram_rd_data[VAL_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_count  <= count;
    end
  end

  assign status      = out_status;
  assign found_value = out_found;
  assign entry_count = out_count;

  always_comb begin
    sts.func     = func_t'(op_func);
    sts.room     = (32'(count) < 32'(capacity)) && (32'(count) < DEPTH);
    sts.empty    = (count == '0);
    sts.hit      = (ram_rd_data[EW-1:VAL_W] == op_key);
    sts.last     = (cmp_idx == last_idx);
    sts.out_free = out_free;
  end

  `UKVT_ASSERT(a_ins_count, clk, rst, cmd.ins_write |=> count == $past(count) + 1'b1, "insert did not grow the count")
  `UKVT_ASSERT(a_del_count, clk, rst, cmd.move_write |=> count == $past(count) - 1'b1, "delete did not shrink the count")
  `UKVT_ASSERT_NEVER(a_ins_room, clk, rst, cmd.ins_write && !sts.room, "insert written past the limit")
  `UKVT_ASSERT_NEVER(a_out_over, clk, rst, cmd.out_load && !out_free, "result overwrote a waiting word")

endmodule

/* rtl/ukvt_ctrl.sv */
// ---------------------------------------------------------------------------
// ukvt_ctrl
// Controller: sequences decode, the entry scan, the delete move and the
// hand-off of each result to the output register.
// ---------------------------------------------------------------------------
module ukvt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ukvt_pkg::sts_t sts,
  output ukvt_pkg::cmd_t cmd
);
  import ukvt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_MOVE   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.rd_sel     = RD_NEXT;
    cmd.res_status = ST_DONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.func)
          FUNC_INSERT: begin
            cmd.res_load = 1'b1;
            if (sts.room) begin
              cmd.ins_write = 1'b1;
            end else begin
              cmd.res_status = ST_FULL;
            end
            state_next = S_RESULT;
          end
          FUNC_SEARCH, FUNC_DELETE: begin
            if (sts.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_MISS;
              state_next     = S_RESULT;
            end else begin
              cmd.rd_sel    = RD_ZERO;
              cmd.idx_clear = 1'b1;
              state_next    = S_SCAN;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            state_next   = S_RESULT;
          end
        endcase
      end
      S_SCAN: begin
        // The RAM word in hand belongs to the slot at the scan index.
        if (sts.hit) begin
          if (sts.func == FUNC_SEARCH) begin
            cmd.res_load      = 1'b1;
            cmd.res_take_data = 1'b1;
            state_next        = S_RESULT;
          end else begin
            cmd.rd_sel = RD_LAST;
            state_next = S_MOVE;
          end
        end else if (sts.last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_MISS;
          state_next     = S_RESULT;
        end else begin
          cmd.idx_step = 1'b1;
        end
      end
      S_MOVE: begin
        cmd.move_write = 1'b1;
        cmd.res_load   = 1'b1;
        state_next     = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/unordered_key_value_table.sv */
// ---------------------------------------------------------------------------
// unordered_key_value_table
// Unsorted key/value table with a fill count and linear search.
// ---------------------------------------------------------------------------
// Each input word is an insert, search or delete; each gives one result word
// with a status, the found value and the entry count after the operation.
// The entries sit in one RAM with a single read port, and search and delete
// walk it from slot 0, one entry per cycle. An insert, an unused code, and a
// search or delete on an empty table go from decode straight to the result
// state; a delete that hits first moves the last entry into the hit slot.
// A new word is taken while the previous result still waits at the output
// register. Keys compare as raw 32-bit patterns; duplicates are stored and
// the lowest slot wins.
// ---------------------------------------------------------------------------
module unordered_key_value_table #(
  parameter int DEPTH = ukvt_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [ukvt_pkg::CNT_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ukvt_pkg::FUNC_W-1:0]          func,
  input  logic signed [ukvt_pkg::KEY_W-1:0]    key,
  input  logic [ukvt_pkg::VAL_W-1:0]           value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ukvt_pkg::STATUS_W-1:0]        status,
  output logic [ukvt_pkg::VAL_W-1:0]           found_value,
  output logic [ukvt_pkg::CNT_W-1:0]           entry_count
);
  import ukvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ukvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ukvt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .func        (func),
    .key         ($unsigned(key)),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_value (found_value),
    .entry_count (entry_count)
  );

endmodule
